@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define CTF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define CTF_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition");
`else
`define CTF_ASSERT(lbl, clk, rstn, prop)
`define CTF_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

@@ rtl/ctf_pkg.sv @@
// ----------------------------------------------------------------------------
// ctf_pkg
// Types, constants and helpers for the complementary tilt filter.
// ----------------------------------------------------------------------------
package ctf_pkg;

    localparam int CW           = 34;
    localparam int CORDIC_STEPS = 28;
    localparam int DIV_STEPS    = 48;
    localparam int CNT_W        = 6;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_BLEND  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 8'd1;

    localparam logic [15:0] BLEND_RESET  = 16'd1311;
    localparam logic [19:0] PERIOD_RESET = 20'd2521;

    localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
    localparam logic signed [CW-1:0] GAIN_INV  = 34'sd652032874;
    localparam logic signed [CW-1:0] Q30_ONE   = 34'sd1073741824;
    localparam logic signed [31:0] TAN_LIMIT   = 32'sd2147483647;
    localparam logic signed [63:0] RATE_LIMIT  = 64'sd1099511627775;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQRT,
        S_VEC_R_GO,
        S_VEC_R,
        S_DIV,
        S_VEC_P_GO,
        S_VEC_P,
        S_ROT_R_GO,
        S_ROT_R,
        S_ROT_P_GO,
        S_ROT_P,
        S_TAN,
        S_MUL,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        M_SR_HI, M_SR_LO, M_GY_T, M_CR_HI, M_CR_LO, M_GZ_T, M_CR_GY, M_SR_GZ,
        M_RX_DH, M_RX_DL, M_R_KEEP, M_R_EST, M_RY_DH, M_RY_DL, M_P_KEEP, M_P_EST
    } t_mstep;

    typedef struct packed {
        logic start;
        logic vec;
    } t_cordic_cmd;

    function automatic logic signed [CW-1:0] arc_lookup(input logic [4:0] i);
        logic [31:0] v;
        unique case (i)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            default: v = 32'h0;
        endcase
        return $signed({2'b00, v});
    endfunction

    // {flip, angle in Q3.30 folded into +-pi/2}
    function automatic logic [CW:0] fold_angle(input logic signed [31:0] a28);
        logic signed [35:0] a;
        logic flip;
        a = 36'(a28) <<< 2;
        flip = 1'b0;
        if (a > Q30_PI) a = a - Q30_TWO_PI;
        if (a < -Q30_PI) a = a + Q30_TWO_PI;
        if (a > Q30_HALF_PI) begin
            a = a - Q30_PI;
            flip = 1'b1;
        end else if (a < -Q30_HALF_PI) begin
            a = a + Q30_PI;
            flip = 1'b1;
        end
        return {flip, a[CW-1:0]};
    endfunction

    function automatic logic signed [40:0] clamp_rate(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > RATE_LIMIT) r = RATE_LIMIT;
        if (v < -RATE_LIMIT) r = -RATE_LIMIT;
        return r[40:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > 64'sd2147483647) r = 64'sd2147483647;
        if (v < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

endpackage

@@ rtl/ctf_if.sv @@
// ----------------------------------------------------------------------------
// ctf_if
// Valid/ready channels of the tilt filter: sample in, angles out, config.
// ----------------------------------------------------------------------------
interface ctf_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                    input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                    output ready);
endinterface

interface ctf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] roll_out;
    logic signed [31:0] pitch_out;
    modport source (output valid, roll_out, pitch_out, input ready);
    modport sink   (input valid, roll_out, pitch_out, output ready);
endinterface

interface ctf_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  idx;
    logic [31:0] data;
    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

@@ rtl/ctf_cordic.sv @@
// ----------------------------------------------------------------------------
// ctf_cordic
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation.
// ----------------------------------------------------------------------------
module ctf_cordic import ctf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cordic_cmd          i_cmd,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [CW-1:0] i_z,
    output logic signed [CW-1:0] o_x,
    output logic signed [CW-1:0] o_y,
    output logic signed [CW-1:0] o_z,
    output logic                 o_busy,
    output logic                 o_done
);
    logic signed [CW-1:0] r_x, r_y, r_z, n_x, n_y, n_z;
    logic signed [CW-1:0] dx, dy, arc;
    logic [4:0] r_step;
    logic       r_busy, r_done, r_vec, minus;

    always_comb begin
        dx    = r_y >>> r_step;
        dy    = r_x >>> r_step;
        arc   = arc_lookup(r_step);
        minus = r_vec ? r_y[CW-1] : !r_z[CW-1];
        if (minus) begin
            n_x = r_x - dx;
            n_y = r_y + dy;
            n_z = r_z - arc;
        end else begin
            n_x = r_x + dx;
            n_y = r_y - dy;
            n_z = r_z + arc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == 5'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_z   <= i_z;
            r_vec <= i_cmd.vec;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

@@ rtl/imu_complementary_tilt_filter_top.sv @@
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter_top
// Roll/pitch complementary filter over accelerometer and gyroscope samples.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   : one beat per IMU sample (three accel axes Q4.12, three gyro
//            axes Q5.11). Ready is high only while the sequencer is idle.
//   o_out  : one beat per sample with the updated roll and pitch in Q3.28.
//   i_cfg  : register writes (0 blend weight, 1 sample period), always
//            ready; write only while no sample is in flight.
// Processing: the shared CORDIC (four runs), the 32-step square root, up
//   to two 48-step restoring divides and 16 products through one 48x18
//   multiplier. One sample is processed at a time.
// Output: a registered result; the next sample is accepted while it waits,
//   and that sample holds in its last step until the receiver takes it.
// Reset: angles cleared, registers back to 1311 and 2521, output empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module imu_complementary_tilt_filter_top import ctf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ctf_in_if.sink     i_in,
    ctf_out_if.source  o_out,
    ctf_cfg_if.sink    i_cfg
);
    t_state r_state, n_state;
    t_mstep r_step, n_step;
    logic   r_phase, n_phase;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic [15:0] r_alpha;
    logic [19:0] r_dt;
    logic signed [31:0] r_roll, r_pitch, n_roll, n_pitch;
    logic r_ov, n_ov;
    logic signed [31:0] r_o_roll, r_o_pitch, n_o_roll, n_o_pitch;

    logic signed [13:0] r_ax, n_ax;
    logic signed [15:0] r_ay, r_az, r_gx, r_gy, r_gz;
    logic [63:0] r_v, n_v, r_r, n_r;
    logic signed [31:0] r_est_r, r_est_p, n_est_r, n_est_p;
    logic signed [CW-1:0] r_ratio, n_ratio;
    logic [47:0] r_num, n_num;
    logic [32:0] r_rem, n_rem, r_den, n_den;
    logic r_neg, n_neg, r_div_tan, n_div_tan, r_flip, n_flip;
    logic signed [CW-1:0] r_sr, r_cr, r_sp, r_cp, n_sr, n_cr, n_sp, n_cp;
    logic signed [31:0] r_tp, n_tp;
    logic signed [65:0] r_prod, n_prod;
    logic signed [63:0] r_tmp, n_tmp, r_acc, n_acc;
    logic signed [40:0] r_rx, r_ry, n_rx, n_ry;

    t_cordic_cmd cordic_cmd;
    logic signed [CW-1:0] c_x, c_y, c_z, cx, cy, cz;
    logic c_busy, c_done;

    logic signed [15:0] ax_in;
    logic signed [13:0] ax_cl;
    logic [27:0] ax_sq;
    logic [63:0] sq_bit, sq_sum;
    logic [33:0] rem_sh;
    logic        q_bit;
    logic [15:0] ay_abs, az_abs;
    logic [CW-1:0] sp_abs, cp_abs;
    logic [CW:0] fold;
    logic signed [47:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [63:0] p64, p_sh11;
    logic signed [63:0] sum64;

    ctf_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cordic_cmd),
        .i_x     (c_x),
        .i_y     (c_y),
        .i_z     (c_z),
        .o_x     (cx),
        .o_y     (cy),
        .o_z     (cz),
        .o_busy  (c_busy),
        .o_done  (c_done)
    );

    assign i_in.ready      = (r_state == S_IDLE);
    assign i_cfg.ready     = 1'b1;
    assign o_out.valid     = r_ov;
    assign o_out.roll_out  = r_o_roll;
    assign o_out.pitch_out = r_o_pitch;

    // multiplier operand select
    always_comb begin
        unique case (r_step)
            M_SR_HI:  begin mul_a = 48'(r_sr);        mul_b = 18'($signed(r_tp[31:16])); end
            M_SR_LO:  begin mul_a = 48'(r_sr);        mul_b = {2'b00, r_tp[15:0]}; end
            M_GY_T:   begin mul_a = r_tmp[47:0];      mul_b = 18'(r_gy); end
            M_CR_HI:  begin mul_a = 48'(r_cr);        mul_b = 18'($signed(r_tp[31:16])); end
            M_CR_LO:  begin mul_a = 48'(r_cr);        mul_b = {2'b00, r_tp[15:0]}; end
            M_GZ_T:   begin mul_a = r_tmp[47:0];      mul_b = 18'(r_gz); end
            M_CR_GY:  begin mul_a = 48'(r_cr);        mul_b = 18'(r_gy); end
            M_SR_GZ:  begin mul_a = 48'(r_sr);        mul_b = 18'(r_gz); end
            M_RX_DH:  begin mul_a = 48'(r_rx);        mul_b = {14'd0, r_dt[19:16]}; end
            M_RX_DL:  begin mul_a = 48'(r_rx);        mul_b = {2'b00, r_dt[15:0]}; end
            M_R_KEEP: begin
                mul_a = r_tmp[47:0];
                mul_b = {1'b0, 17'(17'h10000 - {1'b0, r_alpha})};
            end
            M_R_EST:  begin mul_a = 48'(r_est_r);     mul_b = {2'b00, r_alpha}; end
            M_RY_DH:  begin mul_a = 48'(r_ry);        mul_b = {14'd0, r_dt[19:16]}; end
            M_RY_DL:  begin mul_a = 48'(r_ry);        mul_b = {2'b00, r_dt[15:0]}; end
            M_P_KEEP: begin
                mul_a = r_tmp[47:0];
                mul_b = {1'b0, 17'(17'h10000 - {1'b0, r_alpha})};
            end
            M_P_EST:  begin mul_a = 48'(r_est_p);     mul_b = {2'b00, r_alpha}; end
            default:  begin mul_a = '0;               mul_b = '0; end
        endcase
        n_prod = mul_a * mul_b;
    end

    // sequencer
    always_comb begin
        n_state = r_state;   n_step = r_step;     n_phase = r_phase;  n_cnt = r_cnt;
        n_roll = r_roll;     n_pitch = r_pitch;
        n_ov = r_ov;         n_o_roll = r_o_roll; n_o_pitch = r_o_pitch;
        n_ax = r_ax;         n_v = r_v;           n_r = r_r;
        n_est_r = r_est_r;   n_est_p = r_est_p;   n_ratio = r_ratio;
        n_num = r_num;       n_rem = r_rem;       n_den = r_den;
        n_neg = r_neg;       n_div_tan = r_div_tan; n_flip = r_flip;
        n_sr = r_sr;         n_cr = r_cr;         n_sp = r_sp;        n_cp = r_cp;
        n_tp = r_tp;         n_tmp = r_tmp;       n_acc = r_acc;
        n_rx = r_rx;         n_ry = r_ry;
        cordic_cmd = '0;     c_x = '0;            c_y = '0;           c_z = '0;

        ax_in  = i_in.accel_x;
        ax_cl  = (ax_in > 16'sd4096) ? 14'sd4096 :
                 (ax_in < -16'sd4096) ? -14'sd4096 : ax_in[13:0];
        ax_sq  = 28'($signed(ax_cl) * $signed(ax_cl));
        sq_bit = 64'd1 << {r_cnt[4:0], 1'b0};
        sq_sum = r_r + sq_bit;
        rem_sh = {r_rem, r_num[47]};
        q_bit  = (rem_sh >= {1'b0, r_den});
        ay_abs = r_ay[15] ? 16'(-r_ay) : r_ay;
        az_abs = r_az[15] ? 16'(-r_az) : r_az;
        sp_abs = r_sp[CW-1] ? CW'(-r_sp) : r_sp;
        cp_abs = r_cp[CW-1] ? CW'(-r_cp) : r_cp;
        fold   = fold_angle(r_state == S_ROT_R_GO ? r_roll : r_pitch);
        p64    = r_prod[63:0];
        p_sh11 = p64 >>> 11;
        sum64  = '0;

        if (r_ov && o_out.ready) n_ov = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_ax    = ax_cl;
                    n_v     = {3'b000, 25'(25'd16777216 - {1'b0, ax_sq[23:0]} -
                               {ax_sq[24], 24'd0}), 36'd0};
                    n_r     = '0;
                    n_cnt   = CNT_W'(31);
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (r_v >= sq_sum) begin
                    n_v = r_v - sq_sum;
                    n_r = (r_r >> 1) + sq_bit;
                end else begin
                    n_r = r_r >> 1;
                end
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) n_state = S_VEC_R_GO;
            end
            S_VEC_R_GO: begin
                cordic_cmd.start = 1'b1;
                cordic_cmd.vec   = 1'b1;
                c_x     = r_r[CW-1:0];
                c_y     = CW'(r_ax) <<< 18;
                n_state = S_VEC_R;
            end
            S_VEC_R: begin
                if (c_done) begin
                    n_est_r = cz[CW-1:2];
                    n_neg   = r_ay[15] ^ r_az[15];
                    if (r_ay == '0) begin
                        n_ratio = '0;
                        n_state = S_VEC_P_GO;
                    end else if (ay_abs >= az_abs) begin
                        n_ratio = r_ay[15] ^ r_az[15] ? -Q30_ONE : Q30_ONE;
                        n_state = S_VEC_P_GO;
                    end else begin
                        n_num     = {2'b00, ay_abs, 30'd0};
                        n_rem     = '0;
                        n_den     = {17'd0, az_abs};
                        n_div_tan = 1'b0;
                        n_cnt     = '0;
                        n_state   = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_num = {r_num[46:0], q_bit};
                n_rem = q_bit ? 33'(rem_sh - {1'b0, r_den}) : rem_sh[32:0];
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    if (r_div_tan) begin
                        n_tp    = r_neg ? 32'(-n_num[31:0]) : n_num[31:0];
                        n_step  = M_SR_HI;
                        n_phase = 1'b0;
                        n_state = S_MUL;
                    end else begin
                        n_ratio = r_neg ? CW'(-n_num[CW-1:0]) : n_num[CW-1:0];
                        n_state = S_VEC_P_GO;
                    end
                end
            end
            S_VEC_P_GO: begin
                cordic_cmd.start = 1'b1;
                cordic_cmd.vec   = 1'b1;
                c_x     = Q30_ONE;
                c_y     = r_ratio;
                n_state = S_VEC_P;
            end
            S_VEC_P: begin
                if (c_done) begin
                    n_est_p = cz[CW-1:2];
                    n_state = S_ROT_R_GO;
                end
            end
            S_ROT_R_GO, S_ROT_P_GO: begin
                cordic_cmd.start = 1'b1;
                c_x     = GAIN_INV;
                c_z     = fold[CW-1:0];
                n_flip  = fold[CW];
                n_state = (r_state == S_ROT_R_GO) ? S_ROT_R : S_ROT_P;
            end
            S_ROT_R: begin
                if (c_done) begin
                    n_sr    = r_flip ? CW'(-cy) : cy;
                    n_cr    = r_flip ? CW'(-cx) : cx;
                    n_state = S_ROT_P_GO;
                end
            end
            S_ROT_P: begin
                if (c_done) begin
                    n_sp    = r_flip ? CW'(-cy) : cy;
                    n_cp    = r_flip ? CW'(-cx) : cx;
                    n_state = S_TAN;
                end
            end
            S_TAN: begin
                n_neg = r_sp[CW-1] ^ r_cp[CW-1];
                if (r_sp == '0) begin
                    n_tp    = '0;
                    n_step  = M_SR_HI;
                    n_phase = 1'b0;
                    n_state = S_MUL;
                end else if ({15'd0, sp_abs} >= {cp_abs, 15'd0}) begin
                    n_tp    = (r_sp[CW-1] ^ r_cp[CW-1]) ? -TAN_LIMIT : TAN_LIMIT;
                    n_step  = M_SR_HI;
                    n_phase = 1'b0;
                    n_state = S_MUL;
                end else begin
                    n_num     = {sp_abs[31:0], 16'd0};
                    n_rem     = '0;
                    n_den     = cp_abs[32:0];
                    n_div_tan = 1'b1;
                    n_cnt     = '0;
                    n_state   = S_DIV;
                end
            end
            S_MUL: begin
                n_phase = !r_phase;
                if (r_phase) begin
                    n_step = t_mstep'(r_step + 4'd1);
                    unique case (r_step)
                        M_SR_HI, M_CR_HI: n_tmp = p64 <<< 16;
                        M_SR_LO, M_CR_LO: n_tmp = (r_tmp + p64) >>> 16;
                        M_GY_T:  n_acc = (64'(r_gx) <<< 19) + p_sh11;
                        M_GZ_T:  begin
                            sum64 = r_acc + p_sh11;
                            n_rx  = clamp_rate(sum64);
                        end
                        M_CR_GY: n_tmp = p_sh11;
                        M_SR_GZ: n_ry  = clamp_rate(r_tmp - p_sh11);
                        M_RX_DH, M_RY_DH: n_tmp = p64 <<< 16;
                        M_RX_DL: n_tmp = 64'(r_roll) + ((r_tmp + p64) >>> 22);
                        M_RY_DL: n_tmp = 64'(r_pitch) + ((r_tmp + p64) >>> 22);
                        M_R_KEEP, M_P_KEEP: n_acc = p64;
                        M_R_EST: n_roll  = sat32((r_acc + p64) >>> 16);
                        M_P_EST: begin
                            n_pitch = sat32((r_acc + p64) >>> 16);
                            n_state = S_DONE;
                        end
                        default: n_tmp = r_tmp;
                    endcase
                end
            end
            S_DONE: begin
                if (!r_ov || o_out.ready) begin
                    n_ov      = 1'b1;
                    n_o_roll  = r_roll;
                    n_o_pitch = r_pitch;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= M_SR_HI;
            r_phase <= 1'b0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
            r_roll  <= '0;
            r_pitch <= '0;
            r_alpha <= BLEND_RESET;
            r_dt    <= PERIOD_RESET;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
            r_roll  <= n_roll;
            r_pitch <= n_pitch;
            if (i_cfg.valid && i_cfg.idx == CFG_BLEND) r_alpha <= i_cfg.data[15:0];
            if (i_cfg.valid && i_cfg.idx == CFG_PERIOD) r_dt <= i_cfg.data[19:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_ay <= i_in.accel_y;
            r_az <= i_in.accel_z;
            r_gx <= i_in.gyro_x;
            r_gy <= i_in.gyro_y;
            r_gz <= i_in.gyro_z;
        end
        r_o_roll  <= n_o_roll;   r_o_pitch <= n_o_pitch;
        r_ax      <= n_ax;       r_v       <= n_v;       r_r     <= n_r;
        r_est_r   <= n_est_r;    r_est_p   <= n_est_p;   r_ratio <= n_ratio;
        r_num     <= n_num;      r_rem     <= n_rem;     r_den   <= n_den;
        r_neg     <= n_neg;      r_div_tan <= n_div_tan; r_flip  <= n_flip;
        r_sr      <= n_sr;       r_cr      <= n_cr;      r_sp    <= n_sp;
        r_cp      <= n_cp;       r_tp      <= n_tp;      r_prod  <= n_prod;
        r_tmp     <= n_tmp;      r_acc     <= n_acc;
        r_rx      <= n_rx;       r_ry      <= n_ry;
    end

    `CTF_ASSERT(a_div_cnt, i_clk, i_rst_n, (r_state == S_DIV) |-> (r_cnt < CNT_W'(DIV_STEPS)))
    `CTF_ASSERT_NEVER(a_cordic_restart, i_clk, i_rst_n, cordic_cmd.start && c_busy)
    `CTF_ASSERT(a_out_from_done, i_clk, i_rst_n, $rose(r_ov) |-> $past(r_state == S_DONE))

endmodule
